// ===== hdl/spset_pkg.sv =====
// Shared constants and types for the successor/predecessor set.
package spset_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_LOG  = 6;
	localparam int KEY_W     = 12;

	localparam logic CMD_INSERT = 1'b1;

	// Lowest set bit of one word and highest set bit of another.
	typedef struct packed {
		logic                lo_ok;
		logic [WORD_LOG-1:0] lo_idx;
		logic                hi_ok;
		logic [WORD_LOG-1:0] hi_idx;
	} scan_res_t;

endpackage

// ===== hdl/spset_req_if.sv =====
// Request channel: command and key.
interface spset_req_if import spset_pkg::*;;
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [KEY_W-1:0] key;

	modport source (output valid, cmd, key, input ready);
	modport sink (input valid, cmd, key, output ready);
endinterface

// ===== hdl/spset_rsp_if.sv =====
// Response channel: membership, neighbours and set extremes.
interface spset_rsp_if import spset_pkg::*;;
	logic             valid;
	logic             ready;
	logic             is_member;
	logic             succ_valid;
	logic [KEY_W-1:0] succ_key;
	logic             pred_valid;
	logic [KEY_W-1:0] pred_key;
	logic             set_nonempty;
	logic [KEY_W-1:0] min_out;
	logic [KEY_W-1:0] max_out;

	modport source (output valid, is_member, succ_valid, succ_key, pred_valid, pred_key,
		set_nonempty, min_out, max_out, input ready);
	modport sink (input valid, is_member, succ_valid, succ_key, pred_valid, pred_key,
		set_nonempty, min_out, max_out, output ready);
endinterface

// ===== hdl/successor_predecessor_set_core.sv =====
// A request steps through WORD, SUM, CLUS and FIN; a new one is taken only back in IDLE.
// These steps are three dependent RAM reads: the key's cluster word and summary word,
// then a further summary word, then the target cluster word, followed by the write-back.
// The result register frees the core once loaded; a stalled response holds the final step.
// Reset: state and extremes clear at once; the cluster and summary RAMs are then zeroed,
// one word a cycle over all 2^(UNIVERSE_BITS-6) cluster words (one below 7 bits), with req.ready low.
module successor_predecessor_set_core import spset_pkg::*; #(
	parameter int UNIVERSE_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	spset_req_if.sink    req,
	spset_rsp_if.source  rsp
);

	localparam int KB     = UNIVERSE_BITS;
	localparam int NWORDS = ((1 << KB) + WORD_BITS - 1) / WORD_BITS;
	localparam int NSUM   = (NWORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int CAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SAW    = (NSUM > 1) ? $clog2(NSUM) : 1;

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_WORD = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_CLUS = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	logic [CAW-1:0] clr_q;
	logic [NSUM-1:0] top_q;
	logic [KB-1:0] min_q, max_q;
	logic ne_q;
	logic out_valid_q;

	logic [KB-1:0] in_key, key_q;
	logic [CAW-1:0] in_w, w_q;
	logic [SAW-1:0] in_sw, sw_q;
	logic cmd_q;
	logic [WORD_LOG-1:0] bpos, spos;

	logic [WORD_BITS-1:0] cw_q, smw_q;
	logic mem_q;

	// successor (up) and predecessor (down) search state
	logic u_ok_q, u_cl_q, u_sm_q, d_ok_q, d_cl_q, d_sm_q;
	logic [KB-1:0] u_key_q, d_key_q;
	logic [CAW-1:0] u_word_q, d_word_q, u_word_fin, d_word_fin;
	logic [SAW-1:0] u_sidx_q, d_sidx_q;

	logic t_up_ok, t_dn_ok;
	logic [SAW-1:0] t_up_idx, t_dn_idx;

	logic [WORD_BITS-1:0] up_mask_c, dn_mask_c, up_mask_s, dn_mask_s;
	scan_res_t sc_c, sc_s;

	logic cl_we, sm_we;
	logic [CAW-1:0] cl_waddr, cl_ra, cl_rb;
	logic [SAW-1:0] sm_waddr, sm_ra, sm_rb;
	logic [WORD_BITS-1:0] cl_wdata, cl_da, cl_db, sm_wdata, sm_da, sm_db;

	logic fin_go, ins_go;

	logic is_member_q, succ_valid_q, pred_valid_q, set_nonempty_q;
	logic [KEY_W-1:0] succ_key_q, pred_key_q, min_out_q, max_out_q;

	assign in_key = KB'(req.key);
	assign in_w   = CAW'(in_key >> WORD_LOG);
	assign in_sw  = SAW'(in_w >> WORD_LOG);
	assign bpos   = WORD_LOG'(key_q);
	assign spos   = WORD_LOG'(w_q);

	assign req.ready = (state_q == ST_IDLE);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	assign ins_go    = fin_go && (cmd_q == CMD_INSERT);

	// bits strictly above / below the key's position
	assign up_mask_c = ({WORD_BITS{1'b1}} << bpos) << 1;
	assign dn_mask_c = (WORD_BITS'(1) << bpos) - WORD_BITS'(1);
	assign up_mask_s = ({WORD_BITS{1'b1}} << spos) << 1;
	assign dn_mask_s = (WORD_BITS'(1) << spos) - WORD_BITS'(1);

	spset_scan u_scan_clus (
		.lo_word (state_q == ST_WORD ? (cl_da & up_mask_c) : cl_da),
		.hi_word (state_q == ST_WORD ? (cl_da & dn_mask_c) : cl_db),
		.res     (sc_c)
	);

	spset_scan u_scan_sum (
		.lo_word (state_q == ST_WORD ? (sm_da & up_mask_s) : sm_da),
		.hi_word (state_q == ST_WORD ? (sm_da & dn_mask_s) : sm_db),
		.res     (sc_s)
	);

	// nearest non-empty summary word above and below the key's one
	always_comb begin
		t_up_ok  = 1'b0;
		t_up_idx = '0;
		t_dn_ok  = 1'b0;
		t_dn_idx = '0;
		for (int i = NSUM - 1; i >= 0; i--) begin
			if (top_q[i] && (SAW'(i) > sw_q)) begin
				t_up_ok  = 1'b1;
				t_up_idx = SAW'(i);
			end
		end
		for (int i = 0; i < NSUM; i++) begin
			if (top_q[i] && (SAW'(i) < sw_q)) begin
				t_dn_ok  = 1'b1;
				t_dn_idx = SAW'(i);
			end
		end
	end

	assign u_word_fin = u_sm_q ? u_word_q : CAW'({u_sidx_q, sc_s.lo_idx});
	assign d_word_fin = d_sm_q ? d_word_q : CAW'({d_sidx_q, sc_s.hi_idx});

	assign cl_ra = (state_q == ST_SUM) ? u_word_fin : in_w;
	assign cl_rb = (state_q == ST_SUM) ? d_word_fin : in_w;
	assign sm_ra = (state_q == ST_WORD) ? t_up_idx : in_sw;
	assign sm_rb = (state_q == ST_WORD) ? t_dn_idx : in_sw;

	assign cl_we    = (state_q == ST_CLR) || ins_go;
	assign cl_waddr = (state_q == ST_CLR) ? clr_q : w_q;
	assign cl_wdata = (state_q == ST_CLR) ? '0 : (cw_q | (WORD_BITS'(1) << bpos));
	assign sm_we    = cl_we;
	assign sm_waddr = (state_q == ST_CLR) ? SAW'(clr_q) : sw_q;
	assign sm_wdata = (state_q == ST_CLR) ? '0 : (smw_q | (WORD_BITS'(1) << spos));

	spset_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_clus_ram (
		.clk     (clk),
		.we      (cl_we),
		.waddr   (cl_waddr),
		.wdata   (cl_wdata),
		.raddr_a (cl_ra),
		.raddr_b (cl_rb),
		.rdata_a (cl_da),
		.rdata_b (cl_db)
	);

	spset_ram #(.WIDTH(WORD_BITS), .DEPTH(NSUM)) u_sum_ram (
		.clk     (clk),
		.we      (sm_we),
		.waddr   (sm_waddr),
		.wdata   (sm_wdata),
		.raddr_a (sm_ra),
		.raddr_b (sm_rb),
		.rdata_a (sm_da),
		.rdata_b (sm_db)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			top_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			ne_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ins_go) begin
				top_q[sw_q] <= 1'b1;
				ne_q        <= 1'b1;
				if (!ne_q || (key_q < min_q)) begin
					min_q <= key_q;
				end
				if (!ne_q || (key_q > max_q)) begin
					max_q <= key_q;
				end
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CAW'(1);
					if (clr_q == CAW'(NWORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_WORD;
					end
				end
				ST_WORD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CLUS;
				ST_CLUS: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					key_q <= in_key;
					cmd_q <= req.cmd;
					w_q   <= in_w;
					sw_q  <= in_sw;
				end
			end
			ST_WORD: begin
				cw_q     <= cl_da;
				smw_q    <= sm_da;
				mem_q    <= cl_da[bpos];
				u_ok_q   <= sc_c.lo_ok || sc_s.lo_ok || t_up_ok;
				u_cl_q   <= sc_c.lo_ok;
				u_sm_q   <= sc_s.lo_ok;
				u_key_q  <= KB'({w_q, sc_c.lo_idx});
				u_word_q <= CAW'({sw_q, sc_s.lo_idx});
				u_sidx_q <= t_up_idx;
				d_ok_q   <= sc_c.hi_ok || sc_s.hi_ok || t_dn_ok;
				d_cl_q   <= sc_c.hi_ok;
				d_sm_q   <= sc_s.hi_ok;
				d_key_q  <= KB'({w_q, sc_c.hi_idx});
				d_word_q <= CAW'({sw_q, sc_s.hi_idx});
				d_sidx_q <= t_dn_idx;
			end
			ST_SUM: begin
				u_word_q <= u_word_fin;
				d_word_q <= d_word_fin;
			end
			ST_CLUS: begin
				if (!u_cl_q) begin
					u_key_q <= KB'({u_word_q, sc_c.lo_idx});
				end
				if (!d_cl_q) begin
					d_key_q <= KB'({d_word_q, sc_c.hi_idx});
				end
			end
			default: ;
		endcase
		if (fin_go) begin
			is_member_q    <= mem_q;
			succ_valid_q   <= u_ok_q;
			succ_key_q     <= u_ok_q ? KEY_W'(u_key_q) : '0;
			pred_valid_q   <= d_ok_q;
			pred_key_q     <= d_ok_q ? KEY_W'(d_key_q) : '0;
			set_nonempty_q <= ne_q;
			min_out_q      <= ne_q ? KEY_W'(min_q) : '0;
			max_out_q      <= ne_q ? KEY_W'(max_q) : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.is_member    = is_member_q;
	assign rsp.succ_valid   = succ_valid_q;
	assign rsp.succ_key     = succ_key_q;
	assign rsp.pred_valid   = pred_valid_q;
	assign rsp.pred_key     = pred_key_q;
	assign rsp.set_nonempty = set_nonempty_q;
	assign rsp.min_out      = min_out_q;
	assign rsp.max_out      = max_out_q;

endmodule

// ===== hdl/spset_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module spset_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                     rdata_a,
	output logic [WIDTH-1:0]                     rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== hdl/spset_scan.sv =====
// Bit scan: lowest set bit of lo_word, highest set bit of hi_word.
module spset_scan import spset_pkg::*; (
	input  logic [WORD_BITS-1:0] lo_word,
	input  logic [WORD_BITS-1:0] hi_word,
	output scan_res_t            res
);

	always_comb begin
		res = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (lo_word[i]) begin
				res.lo_ok  = 1'b1;
				res.lo_idx = WORD_LOG'(i);
			end
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			if (hi_word[i]) begin
				res.hi_ok  = 1'b1;
				res.hi_idx = WORD_LOG'(i);
			end
		end
	end

endmodule
